/* design/dbf_pkg.sv */
// Shared types and constants for the data block framing checker.
// No dependencies.
package dbf_pkg;

    localparam logic [1:0] ROLE_CAT    = 2'd0;
    localparam logic [1:0] ROLE_LEN_HI = 2'd1;
    localparam logic [1:0] ROLE_LEN_LO = 2'd2;
    localparam logic [1:0] ROLE_BODY   = 2'd3;

    localparam logic [1:0] VERDICT_ALIGNED  = 2'd0;
    localparam logic [1:0] VERDICT_HDR_CUT  = 2'd1;
    localparam logic [1:0] VERDICT_LEN_LOW  = 2'd2;
    localparam logic [1:0] VERDICT_OVERRUN  = 2'd3;

    localparam logic [15:0] MIN_BLOCK_LENGTH = 16'd4;

    typedef struct packed {
        logic [15:0] offset;
        logic [15:0] length;
        logic [7:0]  len_hi;
        logic [7:0]  category;
        logic [1:0]  fault;
    } t_frame_state;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [1:0]  byte_role;
        logic        block_first;
        logic        block_final;
        logic [7:0]  category;
        logic [15:0] block_length;
        logic        faulted;
        logic        verdict_valid;
        logic [1:0]  verdict;
    } t_frame_result;

endpackage

/* design/datablock_framing_checker_core.sv */
// Data block framing checker, top level. Uses dbf_pkg and dbf_classify.
// Each accepted byte's result is registered and is shown from the next cycle.
// Throughput: one byte per cycle while results are taken; the result register
// refills in the cycle it is taken; input ready follows output ready while full.
// Reset (synchronous, active low) clears framing state and the result valid.
module datablock_framing_checker_core import dbf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_datagram_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_byte_out,
    output logic [1:0]  o_byte_role,
    output logic        o_block_first,
    output logic        o_block_final,
    output logic [7:0]  o_category,
    output logic [15:0] o_block_length,
    output logic        o_faulted,
    output logic        o_verdict_valid,
    output logic [1:0]  o_verdict
);

    t_frame_state  r_state;
    t_frame_state  n_state;
    t_frame_result r_result;
    t_frame_result n_result;
    logic          r_out_valid;
    logic          w_accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    dbf_classify u_classify (
        .i_state         (r_state),
        .i_data_byte     (i_data_byte),
        .i_datagram_last (i_datagram_last),
        .o_next_state    (n_state),
        .o_result        (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_state <= n_state;
            end
            if (o_in_ready) begin
                r_out_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_byte_out      = r_result.byte_out;
    assign o_byte_role     = r_result.byte_role;
    assign o_block_first   = r_result.block_first;
    assign o_block_final   = r_result.block_final;
    assign o_category      = r_result.category;
    assign o_block_length  = r_result.block_length;
    assign o_faulted       = r_result.faulted;
    assign o_verdict_valid = r_result.verdict_valid;
    assign o_verdict       = r_result.verdict;

`ifndef ASSERT_OFF
    // state is clean after the final byte of a datagram
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_datagram_last |=> r_state == '0)
        else $error("framing state not cleared after datagram end");

    a_verdict_matches_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.verdict_valid |->
            (r_result.faulted == (r_result.verdict != VERDICT_ALIGNED)))
        else $error("verdict disagrees with fault flag");

    a_first_is_category: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.block_first |->
            (r_result.byte_role == ROLE_CAT) && !r_result.faulted
            || (r_result.byte_role == ROLE_CAT) && r_result.verdict_valid)
        else $error("block start on a non-category byte");

    a_final_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.block_final |->
            !r_result.faulted && r_result.byte_role == ROLE_BODY)
        else $error("block end marked on a faulted or header byte");
`endif

endmodule

/* design/dbf_classify.sv */
// Per-byte framing decode: role, marks, fault detection and next state.
// Depends on dbf_pkg.
module dbf_classify import dbf_pkg::*; (
    input  t_frame_state  i_state,
    input  logic [7:0]    i_data_byte,
    input  logic          i_datagram_last,
    output t_frame_state  o_next_state,
    output t_frame_result o_result
);

    t_frame_state n_st;
    logic [16:0]  w_offset_inc;
    logic [15:0]  w_assembled;

    assign w_offset_inc = {1'b0, i_state.offset} + 17'd1;
    assign w_assembled  = {i_state.len_hi, i_data_byte};

    always_comb begin
        n_st = i_state;
        o_result.byte_out      = i_data_byte;
        o_result.byte_role     = ROLE_BODY;
        o_result.block_first   = 1'b0;
        o_result.block_final   = 1'b0;
        o_result.category      = i_state.category;
        o_result.block_length  = i_state.length;

        if (i_state.fault != VERDICT_ALIGNED) begin
            // checking stopped; pass bytes through with the held fields
        end else begin
            case (i_state.offset)
                16'd0: begin
                    o_result.byte_role    = ROLE_CAT;
                    o_result.block_first  = 1'b1;
                    o_result.category     = i_data_byte;
                    o_result.block_length = '0;
                    n_st.category = i_data_byte;
                    n_st.length   = '0;
                    n_st.offset   = 16'd1;
                    if (i_datagram_last) begin
                        n_st.fault = VERDICT_HDR_CUT;
                    end
                end
                16'd1: begin
                    o_result.byte_role    = ROLE_LEN_HI;
                    o_result.block_length = '0;
                    n_st.len_hi = i_data_byte;
                    n_st.offset = 16'd2;
                    if (i_datagram_last) begin
                        n_st.fault = VERDICT_HDR_CUT;
                    end
                end
                16'd2: begin
                    o_result.byte_role    = ROLE_LEN_LO;
                    o_result.block_length = w_assembled;
                    n_st.length = w_assembled;
                    n_st.offset = 16'd3;
                    if (i_datagram_last) begin
                        n_st.fault = VERDICT_HDR_CUT;
                    end else if (w_assembled < MIN_BLOCK_LENGTH) begin
                        n_st.fault = VERDICT_LEN_LOW;
                    end
                end
                default: begin
                    if (w_offset_inc == {1'b0, i_state.length}) begin
                        o_result.block_final = 1'b1;
                        n_st.offset = '0;
                    end else begin
                        n_st.offset = w_offset_inc[15:0];
                        if (i_datagram_last) begin
                            n_st.fault = VERDICT_OVERRUN;
                        end
                    end
                end
            endcase
        end

        o_result.faulted       = (n_st.fault != VERDICT_ALIGNED);
        o_result.verdict_valid = i_datagram_last;
        o_result.verdict       = i_datagram_last ? n_st.fault : VERDICT_ALIGNED;

        // every datagram starts from a clean state
        o_next_state = i_datagram_last ? '0 : n_st;
    end

endmodule
